// ===== rtl/core/ut2c_pkg.sv =====
// Shared types, constants and lookup functions for the timestamp to calendar converter
package ut2c_pkg;

    localparam logic [31:0] ZONE_OFFSET_S = 32'd28800;
    localparam logic [7:0]  BASE_YEAR     = 8'd70;
    localparam logic [7:0]  CENTURY_LEN   = 8'd100;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    localparam logic [10:0] LEAP_DAY      = 11'd60;
    localparam logic [15:0] EPOCH_WDAY    = 16'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_BACK,
        S_DIV_FIX,
        S_YEAR,
        S_CENTURY,
        S_MONTH,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WEEK,
        DIV_BLOCK
    } t_div_sel;

    // divisor for each division step
    function automatic logic [10:0] div_const(input t_div_sel sel);
        logic [10:0] d;
        case (sel)
            DIV_SEC:   d = 11'd60;
            DIV_MIN:   d = 11'd60;
            DIV_HOUR:  d = 11'd24;
            DIV_WEEK:  d = 11'd7;
            DIV_BLOCK: d = 11'd1461;
            default:   d = 11'd60;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor): quotient estimate is low by at most one
    function automatic logic [31:0] div_recip(input t_div_sel sel);
        logic [31:0] m;
        case (sel)
            DIV_SEC:   m = 32'd71582788;
            DIV_MIN:   m = 32'd71582788;
            DIV_HOUR:  m = 32'd178956970;
            DIV_WEEK:  m = 32'd613566756;
            DIV_BLOCK: m = 32'd2939744;
            default:   m = 32'd71582788;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/ut2c_if.sv =====
// Valid/ready channel interfaces for timestamp words and calendar words
interface ut2c_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ut2c_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [2:0] weekday_number;
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic [6:0] year_of_century;

    modport source (
        output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
        output weekday_number, output day_of_month, output month_number,
        output year_of_century, input ready
    );
    modport sink (
        input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
        input weekday_number, input day_of_month, input month_number,
        input year_of_century, output ready
    );
endinterface

// ===== rtl/core/unix_time_to_calendar_unit.sv =====
// Unix timestamp to UTC+8 calendar fields: sequencer around one shared multiplier
// Each of the five constant divisions passes through multiply, back-multiply and fix states,
// then the year, century and month steps follow; the result word is then offered on o_out.
// A new word is taken only after the last result has been taken; ready is high only while
// idle and the result word is held until taken. Synchronous active-low reset returns the
// sequencer to idle with no result pending; the datapath registers are not reset.
module unix_time_to_calendar_unit
    import ut2c_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ut2c_in_if.sink      i_in,
    ut2c_out_if.source   o_out
);

    t_state      r_state, n_state;
    t_div_sel    r_dsel, n_dsel;
    logic [31:0] r_x, n_x;
    logic [63:0] r_prod;
    logic [31:0] r_q;
    logic [15:0] r_days, n_days;
    logic [7:0]  r_year, n_year;
    logic [10:0] r_doy, n_doy;
    logic [3:0]  r_mon, n_mon;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic [2:0]  r_wday, n_wday;
    logic [4:0]  r_mday, n_mday;
    logic [3:0]  r_month, n_month;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] dconst, rem_raw, rem_fix, q_fix;
    logic        fix;
    logic        leap;
    logic [8:0]  ylen;
    logic [10:0] doy1;
    logic [4:0]  mlen;

    // the one multiplier: reciprocal pass, then quotient times divisor
    always_comb begin
        dconst = {21'd0, div_const(r_dsel)};
        if (r_state == S_DIV_MUL) begin
            mul_a = r_x;
            mul_b = div_recip(r_dsel);
        end else begin
            mul_a = r_prod[63:32];
            mul_b = dconst;
        end
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb begin
        rem_raw = r_x - r_prod[31:0];
        fix     = (rem_raw >= dconst);
        rem_fix = fix ? (rem_raw - dconst) : rem_raw;
        q_fix   = fix ? (r_q + 32'd1) : r_q;
        leap    = (r_year[1:0] == 2'd0);
        ylen    = leap ? 9'd366 : 9'd365;
        doy1    = r_doy + 11'd1;
        mlen    = month_len(r_mon);
    end

    always_comb begin
        n_state = r_state;
        n_dsel  = r_dsel;
        n_x     = r_x;
        n_days  = r_days;
        n_year  = r_year;
        n_doy   = r_doy;
        n_mon   = r_mon;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_wday  = r_wday;
        n_mday  = r_mday;
        n_month = r_month;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x     = i_in.epoch_seconds + ZONE_OFFSET_S;
                    n_dsel  = DIV_SEC;
                    n_state = S_DIV_MUL;
                end
            end
            S_DIV_MUL:  n_state = S_DIV_BACK;
            S_DIV_BACK: n_state = S_DIV_FIX;
            S_DIV_FIX: begin
                n_state = S_DIV_MUL;
                case (r_dsel)
                    DIV_SEC: begin
                        n_sec  = rem_fix[5:0];
                        n_x    = q_fix;
                        n_dsel = DIV_MIN;
                    end
                    DIV_MIN: begin
                        n_min  = rem_fix[5:0];
                        n_x    = q_fix;
                        n_dsel = DIV_HOUR;
                    end
                    DIV_HOUR: begin
                        n_hour = rem_fix[4:0];
                        n_days = q_fix[15:0];
                        n_x    = {16'd0, q_fix[15:0] + EPOCH_WDAY};
                        n_dsel = DIV_WEEK;
                    end
                    DIV_WEEK: begin
                        n_wday = (rem_fix[2:0] == 3'd0) ? 3'd7 : rem_fix[2:0];
                        n_x    = {16'd0, r_days};
                        n_dsel = DIV_BLOCK;
                    end
                    DIV_BLOCK: begin
                        // whole four-year blocks since 1970
                        n_year  = {q_fix[5:0], 2'b00} + BASE_YEAR;
                        n_doy   = rem_fix[10:0];
                        n_state = S_YEAR;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_YEAR: begin
                if (r_doy < {2'd0, ylen}) begin
                    n_state = S_CENTURY;
                end else begin
                    n_doy  = r_doy - {2'd0, ylen};
                    n_year = r_year + 8'd1;
                end
            end
            S_CENTURY: begin
                if (r_year >= CENTURY_LEN) begin
                    n_year = r_year - CENTURY_LEN;
                end else if (leap && doy1 == LEAP_DAY) begin
                    n_mday  = 5'd29;
                    n_month = 4'd2;
                    n_state = S_OUT;
                end else begin
                    n_doy   = (leap && doy1 > LEAP_DAY) ? r_doy : doy1;
                    n_mon   = 4'd0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (r_mon < LAST_MONTH && {6'd0, mlen} < r_doy) begin
                    n_doy = r_doy - {6'd0, mlen};
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_mday  = r_doy[4:0];
                    n_month = r_mon + 4'd1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsel  <= n_dsel;
        r_x     <= n_x;
        r_days  <= n_days;
        r_year  <= n_year;
        r_doy   <= n_doy;
        r_mon   <= n_mon;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hour  <= n_hour;
        r_wday  <= n_wday;
        r_mday  <= n_mday;
        r_month <= n_month;
        if (r_state == S_DIV_MUL || r_state == S_DIV_BACK) begin
            r_prod <= mul_p;
        end
        if (r_state == S_DIV_BACK) begin
            r_q <= r_prod[63:32];
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = (r_state == S_OUT);
    assign o_out.second_of_minute = r_sec;
    assign o_out.minute_of_hour   = r_min;
    assign o_out.hour_of_day      = r_hour;
    assign o_out.weekday_number   = r_wday;
    assign o_out.day_of_month     = r_mday;
    assign o_out.month_number     = r_month;
    assign o_out.year_of_century  = r_year[6:0];

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("accepted a second word while busy");

    a_month_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_mon <= LAST_MONTH))
        else $error("month walk ran past December");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_number >= 4'd1 && o_out.month_number <= 4'd12 &&
                         o_out.day_of_month != 5'd0 && o_out.weekday_number != 3'd0 &&
                         o_out.year_of_century < 7'd100))
        else $error("calendar word out of range");

    a_year_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CENTURY && $past(r_state) == S_YEAR) |-> (r_doy < 11'd366))
        else $error("day of year left over after year steps");

endmodule
